### sv/tcse_pkg.sv
// Shared constants and codes for the triangle counter.
`timescale 1ns / 1ps

package tcse_pkg;

	localparam int DEFAULT_MAX_NODES = 1024;
	localparam int DEFAULT_MAX_EDGES = 4096;

	localparam int NODE_W    = 10;
	localparam int COUNT_W   = 20;
	localparam int IN_DATA_W = 24;
	localparam int OUT_DATA_W = 24;
	localparam int USER_W    = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [USER_W-1:0] {
		ACT_CLEAR = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_COUNT = 2'd2
	} action_t;

endpackage

### sv/triangle_count_sorted_edges_unit.sv
// Top level of the triangle counter over a sorted, oriented edge list.
`timescale 1ns / 1ps

// Requests arrive on the s_axis channel. The tuser field selects clear, load or count; tdata
// carries the source and target node of a load. Loads are taken one per cycle while idle: the
// edge is appended to the edge memory and the node memory entry of its source is updated in
// the next cycle, with a forwarding register covering back-to-back loads to the same source.
// A clear empties the store and then sweeps the node memory, one entry per cycle, which
// holds tready low until the sweep ends. The same sweep runs right after reset.
// A count walks every stored edge through the single read port of each memory. Each edge
// passes the states S_EDGE, S_NODEU, S_NODEV and S_PAIR; when its two nodes both have edges,
// their target lists are merged, each merge step through S_MA, S_MB and S_MC, and a last
// S_MA ends the merge. S_DONE then finishes the count: the result becomes valid as the unit
// leaves S_DONE, and tready returns in that same cycle.
// The result appears on m_axis and stays in the output register until tready is high;
// loads and clears are still taken while it waits, and a second count finishes its walk
// and then holds until the output register is free.
// Dropped loads (store full) are recorded and reported with every count until a clear.

module triangle_count_sorted_edges_unit
	import tcse_pkg::*;
#(
	parameter int MAX_NODES = DEFAULT_MAX_NODES,
	parameter int MAX_EDGES = DEFAULT_MAX_EDGES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [9:0] source_node, [19:10] target_node, [23:20] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [1:0] action
	input  logic [USER_W-1:0]     s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [19:0] triangle_count, [20] edges_dropped, [23:21] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int EW  = $clog2(MAX_EDGES);
	localparam int CW  = EW + 1;
	localparam int NEW = 1 + 2 * EW;
	localparam int EDW = 2 * NODE_W;

	typedef enum logic [9:0] {
		S_CLEAR = 10'b00_0000_0001,
		S_IDLE  = 10'b00_0000_0010,
		S_EDGE  = 10'b00_0000_0100,
		S_NODEU = 10'b00_0000_1000,
		S_NODEV = 10'b00_0001_0000,
		S_PAIR  = 10'b00_0010_0000,
		S_MA    = 10'b00_0100_0000,
		S_MB    = 10'b00_1000_0000,
		S_MC    = 10'b01_0000_0000,
		S_DONE  = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	logic [NW-1:0]      clr_cnt_q;
	logic [CW-1:0]      loaded_q;
	logic               overflow_q;
	logic               ld_valid_s1;
	logic [NW-1:0]      ld_node_s1;
	logic [EW-1:0]      ld_idx_s1;
	logic               fwd_valid_q;
	logic [NW-1:0]      fwd_node_q;
	logic [NEW-1:0]     fwd_data_q;
	logic [CW-1:0]      edge_i_q;
	logic [NODE_W-1:0]  v_q;
	logic [NEW-1:0]     node_a_q;
	logic [CW-1:0]      pa_q, pb_q;
	logic [EW-1:0]      ea_q, eb_q;
	logic [NODE_W-1:0]  ta_q;
	logic [COUNT_W-1:0] total_q;
	logic               out_valid_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_drop_q;

	action_t            in_act;
	logic [NODE_W-1:0]  in_src, in_dst;
	logic               accept, in_ok, store_full, load_go, last_edge, out_free;
	logic               both_has, merge_on;
	logic [NODE_W-1:0]  tb;

	logic               edge_we;
	logic [EW-1:0]      edge_waddr, edge_raddr;
	logic [EDW-1:0]     edge_wdata, edge_rdata;
	logic               node_we;
	logic [NW-1:0]      node_waddr, node_raddr;
	logic [NEW-1:0]     node_wdata, node_rdata;
	logic [NEW-1:0]     ld_cur, ld_new;

	assign in_act     = action_t'(s_axis_tuser);
	assign in_src     = s_axis_tdata[NODE_W-1:0];
	assign in_dst     = s_axis_tdata[2*NODE_W-1:NODE_W];
	assign accept     = s_axis_tvalid && s_axis_tready;
	assign in_ok      = (32'(in_src) < MAX_NODES) && (32'(in_dst) < MAX_NODES);
	assign store_full = (loaded_q == CW'(MAX_EDGES));
	assign load_go    = accept && (in_act == ACT_LOAD) && in_ok && !store_full;
	assign last_edge  = ((edge_i_q + CW'(1)) == loaded_q);
	assign out_free   = !out_valid_q || m_axis_tready;
	assign both_has   = node_a_q[NEW-1] && node_rdata[NEW-1];
	assign merge_on   = (pa_q <= {1'b0, ea_q}) && (pb_q <= {1'b0, eb_q});
	assign tb         = edge_rdata[EDW-1:NODE_W];

	assign ld_cur = (fwd_valid_q && (fwd_node_q == ld_node_s1)) ? fwd_data_q : node_rdata;
	assign ld_new = {1'b1, ld_cur[NEW-1] ? ld_cur[2*EW-1:EW] : ld_idx_s1, ld_idx_s1};

	assign edge_we    = load_go;
	assign edge_waddr = loaded_q[EW-1:0];
	assign edge_wdata = {in_dst, in_src};

	always_comb begin
		if (state_q == S_MA) begin
			edge_raddr = pa_q[EW-1:0];
		end else if (state_q == S_MB) begin
			edge_raddr = pb_q[EW-1:0];
		end else begin
			edge_raddr = edge_i_q[EW-1:0];
		end
	end

	always_comb begin
		if (state_q == S_IDLE) begin
			node_raddr = NW'(in_src);
		end else if (state_q == S_NODEU) begin
			node_raddr = NW'(edge_rdata[NODE_W-1:0]);
		end else begin
			node_raddr = NW'(v_q);
		end
	end

	assign node_we    = (state_q == S_CLEAR) || ld_valid_s1;
	assign node_waddr = (state_q == S_CLEAR) ? clr_cnt_q : ld_node_s1;
	assign node_wdata = (state_q == S_CLEAR) ? '0 : ld_new;

	tcse_ram #(
		.WIDTH(EDW),
		.DEPTH(MAX_EDGES)
	) u_edge_ram (
		.clk  (clk),
		.we   (edge_we),
		.waddr(edge_waddr),
		.wdata(edge_wdata),
		.raddr(edge_raddr),
		.rdata(edge_rdata)
	);

	tcse_ram #(
		.WIDTH(NEW),
		.DEPTH(MAX_NODES)
	) u_node_ram (
		.clk  (clk),
		.we   (node_we),
		.waddr(node_waddr),
		.wdata(node_wdata),
		.raddr(node_raddr),
		.rdata(node_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_cnt_q == NW'(MAX_NODES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept && (in_act == ACT_CLEAR)) begin
					state_d = S_CLEAR;
				end else if (accept && (in_act == ACT_COUNT)) begin
					state_d = (loaded_q == '0) ? S_DONE : S_EDGE;
				end
			end
			S_EDGE:  state_d = S_NODEU;
			S_NODEU: state_d = S_NODEV;
			S_NODEV: state_d = S_PAIR;
			S_PAIR: begin
				if (both_has) begin
					state_d = S_MA;
				end else begin
					state_d = last_edge ? S_DONE : S_EDGE;
				end
			end
			S_MA: begin
				if (merge_on) begin
					state_d = S_MB;
				end else begin
					state_d = last_edge ? S_DONE : S_EDGE;
				end
			end
			S_MB: state_d = S_MC;
			S_MC: state_d = S_MA;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			loaded_q    <= '0;
			overflow_q  <= 1'b0;
			ld_valid_s1 <= 1'b0;
			fwd_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ld_valid_s1 <= load_go;
			fwd_valid_q <= ld_valid_s1;
			if (state_q == S_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + NW'(1);
			end else begin
				clr_cnt_q <= '0;
			end
			if (accept && (in_act == ACT_CLEAR)) begin
				loaded_q   <= '0;
				overflow_q <= 1'b0;
			end else if (load_go) begin
				loaded_q <= loaded_q + CW'(1);
			end else if (accept && (in_act == ACT_LOAD) && in_ok) begin
				overflow_q <= 1'b1;
			end
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ld_node_s1 <= NW'(in_src);
		ld_idx_s1  <= loaded_q[EW-1:0];
		fwd_node_q <= ld_node_s1;
		fwd_data_q <= ld_new;
		if ((state_q == S_DONE) && out_free) begin
			out_count_q <= total_q;
			out_drop_q  <= overflow_q;
		end
		unique case (state_q)
			S_IDLE: begin
				edge_i_q <= '0;
				total_q  <= '0;
			end
			S_NODEU: v_q <= edge_rdata[EDW-1:NODE_W];
			S_NODEV: node_a_q <= node_rdata;
			S_PAIR: begin
				pa_q <= {1'b0, node_a_q[2*EW-1:EW]};
				ea_q <= node_a_q[EW-1:0];
				pb_q <= {1'b0, node_rdata[2*EW-1:EW]};
				eb_q <= node_rdata[EW-1:0];
				if (!both_has) begin
					edge_i_q <= edge_i_q + CW'(1);
				end
			end
			S_MA: begin
				if (!merge_on) begin
					edge_i_q <= edge_i_q + CW'(1);
				end
			end
			S_MB: ta_q <= edge_rdata[EDW-1:NODE_W];
			S_MC: begin
				if (ta_q == tb) begin
					if (total_q != COUNT_MAX) begin
						total_q <= total_q + COUNT_W'(1);
					end
					pa_q <= pa_q + CW'(1);
					pb_q <= pb_q + CW'(1);
				end else if (ta_q > tb) begin
					pb_q <= pb_q + CW'(1);
				end else begin
					pa_q <= pa_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_DATA_W - COUNT_W - 1)'(0), out_drop_q, out_count_q};

endmodule

### sv/tcse_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module tcse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/tcse_checker.sv
// Port-level checker for the triangle counter, bound to the top level.
`timescale 1ns / 1ps

module tcse_checker
	import tcse_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [USER_W-1:0]     s_axis_tuser,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic       in_acc, count_acc, clear_acc, out_acc;
	logic [1:0] pend_q;

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign count_acc = in_acc && (s_axis_tuser == ACT_COUNT);
	assign clear_acc = in_acc && (s_axis_tuser == ACT_CLEAR);
	assign out_acc   = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(count_acc) - 2'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Result request changed while stalled.");

	a_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pend_q != 2'd0)
		else $error("Result request without a pending count.");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		clear_acc |=> !s_axis_tready)
		else $error("Request taken during the node sweep after a clear.");

	a_count_busy: assert property (@(posedge clk) disable iff (!arst_n)
		count_acc |=> !s_axis_tready)
		else $error("Request taken while a count walk has just started.");

endmodule

bind triangle_count_sorted_edges_unit tcse_checker u_tcse_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

### dv/triangle_count_sorted_edges_unit_tb.sv
// Self-checking testbench for the sorted-edge triangle counter, with its own edge-store predictor.
`timescale 1ns / 1ps

module triangle_count_sorted_edges_unit_tb;
	import tcse_pkg::*;

	localparam logic [USER_W-1:0] ACT_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 14_000_000;
	localparam int RANDOM_REQUESTS = 1150;

	typedef struct packed {
		logic [COUNT_W-1:0] triangles;
		logic               dropped;
	} tally_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [USER_W-1:0]     s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	logic [NODE_W-1:0]           edge_src [DEFAULT_MAX_EDGES];
	logic [NODE_W-1:0]           edge_dst [DEFAULT_MAX_EDGES];
	logic [11:0]                 node_first [DEFAULT_MAX_NODES];
	logic [11:0]                 node_last [DEFAULT_MAX_NODES];
	logic [DEFAULT_MAX_NODES-1:0] node_marked = '0;
	int                          stored_edges = 0;
	logic                        dropped_flag = 1'b0;

	tally_t pending_totals [$];
	int     mismatches = 0;
	int     requests_sent = 0;
	int     stall_cycles = 0;
	bit     steady = 1'b0;

	triangle_count_sorted_edges_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint shared_targets(input int a, input int b);
		int     pa;
		int     ea;
		int     pb;
		int     eb;
		longint hits;
		pa = node_first[a];
		ea = node_last[a];
		pb = node_first[b];
		eb = node_last[b];
		hits = 0;
		while (pa <= ea && pb <= eb && pa < DEFAULT_MAX_EDGES && pb < DEFAULT_MAX_EDGES) begin
			if (edge_dst[pa] == edge_dst[pb]) begin
				hits++;
				pa++;
				pb++;
			end else if (edge_dst[pa] > edge_dst[pb]) begin
				pb++;
			end else begin
				pa++;
			end
		end
		return hits;
	endfunction

	function automatic logic [COUNT_W-1:0] tally_triangles();
		longint total;
		int     u;
		int     v;
		total = 0;
		for (int i = 0; i < stored_edges; i++) begin
			u = edge_src[i];
			v = edge_dst[i];
			if (node_marked[u] && node_marked[v]) begin
				total += shared_targets(u, v);
				if (total > longint'(COUNT_MAX))
					total = longint'(COUNT_MAX);
			end
		end
		return total[COUNT_W-1:0];
	endfunction

	task automatic accept_request(input logic [USER_W-1:0] act,
			input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst);
		tally_t expected;
		case (act)
			ACT_CLEAR: begin
				node_marked = '0;
				stored_edges = 0;
				dropped_flag = 1'b0;
			end
			ACT_LOAD: begin
				if (stored_edges >= DEFAULT_MAX_EDGES) begin
					dropped_flag = 1'b1;
				end else begin
					edge_src[stored_edges] = src;
					edge_dst[stored_edges] = dst;
					if (!node_marked[src]) begin
						node_first[src] = 12'(stored_edges);
						node_marked[src] = 1'b1;
					end
					node_last[src] = 12'(stored_edges);
					stored_edges++;
				end
			end
			ACT_COUNT: begin
				expected = '{tally_triangles(), dropped_flag};
				pending_totals.insert(pending_totals.size(), expected);
			end
			default: begin
			end
		endcase
	endtask

	// The valid line is only lowered for an idle gap, so back-to-back requests keep it high.
	task automatic issue_request(input logic [USER_W-1:0] act,
			input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst);
		while (!steady && $urandom_range(0, 99) < 15) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {{(IN_DATA_W - 2 * NODE_W){1'b0}}, dst, src};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		accept_request(act, src, dst);
		if (act != ACT_UNUSED)
			requests_sent++;
	endtask

	task automatic log_mismatch(input string what, input tally_t want,
			input logic [OUT_DATA_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected count %0d dropped %0d, got count %0d dropped %0d",
				$time, what, want.triangles, want.dropped, got[COUNT_W-1:0], got[COUNT_W]);
	endtask

	always @(posedge clk) begin
		m_axis_tready <= steady || ($urandom_range(0, 99) >= 15);
	end

	always @(posedge clk) begin
		tally_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_totals.size() == 0) begin
				log_mismatch("unexpected result", '0, m_axis_tdata);
			end else begin
				want = pending_totals.pop_front();
				if (m_axis_tdata[COUNT_W-1:0] !== want.triangles
						|| m_axis_tdata[COUNT_W] !== want.dropped)
					log_mismatch("result mismatch", want, m_axis_tdata);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("triangle_count_sorted_edges_unit regression: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic test_empty_and_unused();
		issue_request(ACT_COUNT, '0, '0);
		issue_request(ACT_UNUSED, '1, '1);
		issue_request(ACT_COUNT, '0, '0);
	endtask

	task automatic test_single_triangle();
		issue_request(ACT_LOAD, 10'd1, 10'd2);
		issue_request(ACT_LOAD, 10'd1, 10'd3);
		issue_request(ACT_LOAD, 10'd2, 10'd3);
		issue_request(ACT_COUNT, '0, '0);
		issue_request(ACT_CLEAR, '0, '0);
		issue_request(ACT_COUNT, '0, '0);
	endtask

	task automatic test_extreme_nodes();
		issue_request(ACT_LOAD, 10'd0, 10'd512);
		issue_request(ACT_LOAD, 10'd0, 10'd1023);
		issue_request(ACT_LOAD, 10'd512, 10'd1023);
		issue_request(ACT_LOAD, 10'd1023, 10'd1023);
		issue_request(ACT_COUNT, '0, '0);
		issue_request(ACT_CLEAR, '0, '0);
	endtask

	// Node 5 has edges on both sides of node 7's edge, so its range spans a foreign entry.
	task automatic test_unsorted_feed();
		issue_request(ACT_LOAD, 10'd5, 10'd9);
		issue_request(ACT_LOAD, 10'd7, 10'd9);
		issue_request(ACT_LOAD, 10'd5, 10'd7);
		issue_request(ACT_LOAD, 10'd7, 10'd8);
		issue_request(ACT_COUNT, '0, '0);
		issue_request(ACT_CLEAR, '0, '0);
	endtask

	task automatic test_store_full();
		logic [NODE_W-1:0] src;
		steady = 1'b1;
		for (int i = 0; i < DEFAULT_MAX_EDGES; i++) begin
			src = NODE_W'(i >> 2);
			issue_request(ACT_LOAD, src, src + NODE_W'(1 + (i & 3)));
		end
		steady = 1'b0;
		issue_request(ACT_COUNT, '0, '0);
		issue_request(ACT_LOAD, 10'd1023, 10'd0);
		issue_request(ACT_COUNT, '0, '0);
		issue_request(ACT_CLEAR, '0, '0);
		issue_request(ACT_COUNT, '0, '0);
	endtask

	// Two interleaved sources whose edges all point at the second one: every merge step hits,
	// so the total passes the counter's ceiling.
	task automatic test_count_saturation();
		for (int i = 0; i < 1026; i++)
			issue_request(ACT_LOAD, (i % 2 == 0) ? 10'd3 : 10'd700, 10'd700);
		issue_request(ACT_COUNT, '0, '0);
		issue_request(ACT_CLEAR, '0, '0);
	endtask

	task automatic test_random_traffic();
		logic [NODE_W-1:0] ids [8];
		int                start;
		int                nodes;
		int                pick;
		int                seq;
		bit                ordered;
		start = requests_sent;
		seq = 0;
		while (requests_sent - start < RANDOM_REQUESTS) begin
			steady = (seq >= 15 && seq < 30);
			if (stored_edges > 200 || $urandom_range(0, 99) < 80)
				issue_request(ACT_CLEAR, NODE_W'($urandom()), NODE_W'($urandom()));
			nodes = $urandom_range(3, 8);
			ordered = ($urandom_range(0, 99) < 80);
			ids[0] = ordered ? NODE_W'($urandom_range(0, 300)) : NODE_W'($urandom());
			for (int j = 1; j < nodes; j++)
				ids[j] = ordered ? ids[j - 1] + NODE_W'($urandom_range(1, 90))
					: NODE_W'($urandom());
			for (int a = 0; a < nodes; a++) begin
				for (int b = a + 1; b < nodes; b++) begin
					pick = $urandom_range(0, 99);
					if (pick < 4)
						issue_request(ACT_UNUSED, NODE_W'($urandom()), NODE_W'($urandom()));
					else if (pick < 8)
						issue_request(ACT_LOAD, NODE_W'($urandom()), NODE_W'($urandom()));
					else if (pick < 11)
						issue_request(ACT_COUNT, NODE_W'($urandom()), NODE_W'($urandom()));
					if ($urandom_range(0, 99) < 60)
						issue_request(ACT_LOAD, ids[a], ids[b]);
				end
			end
			issue_request(ACT_COUNT, NODE_W'($urandom()), NODE_W'($urandom()));
			seq++;
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_unused();
		test_single_triangle();
		test_extreme_nodes();
		test_unsorted_feed();
		test_store_full();
		test_count_saturation();
		test_random_traffic();
		s_axis_tvalid <= 1'b0;
		while (pending_totals.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("triangle_count_sorted_edges_unit regression: pass");
		else
			$display("triangle_count_sorted_edges_unit regression: fail");
		$finish;
	end

endmodule

### filelist.f
sv/tcse_pkg.sv
sv/tcse_ram.sv
sv/triangle_count_sorted_edges_unit.sv
sv/tcse_checker.sv
dv/triangle_count_sorted_edges_unit_tb.sv
